// ===== sv/bzs_pkg.sv =====
// bzs_pkg: shared widths, types and the de casteljau step sequence for the bezier sampler
// no dependencies; imported by every other file of the block
`default_nettype none
package bzs_pkg;

	localparam int MaxPoints   = 64;
	localparam int MaxInterior = MaxPoints - 2;
	localparam int IdxW        = $clog2(MaxPoints);
	localparam int CoordW      = 32;
	localparam int StepW       = 31;
	localparam int DistW       = 36;
	localparam int SqW         = 66;
	localparam int RootW       = SqW / 2;
	localparam int FracW       = 16;
	localparam int TW          = FracW + 1;
	localparam int MulW        = 34;
	localparam int OpCnt       = 9;
	localparam int OpW         = $clog2(OpCnt);

	typedef logic signed [CoordW-1:0] coord_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SQX, S_SQY, S_SQSUM, S_SQRT, S_DIVN,
		S_PT, S_DIVT, S_LOAD, S_OP, S_ADD, S_OUT
	} state_t;

	typedef enum logic {OP_LERP, OP_DROP} op_t;

	// lerp w0,w1 into the tail, or drop the head, over a four-entry queue
	localparam op_t OpSeq [OpCnt] = '{OP_LERP, OP_LERP, OP_LERP, OP_DROP,
		OP_LERP, OP_LERP, OP_DROP, OP_DROP, OP_LERP};

	typedef struct packed {
		logic busy;
		logic done;
	} unit_status_t;

endpackage
`default_nettype wire

// ===== sv/bzs_in_if.sv =====
// bzs_in_if: request channel of the bezier sampler, four control points and step length
// depends on bzs_pkg
`default_nettype none
interface bzs_in_if;
	import bzs_pkg::*;
	logic              valid;
	logic              ready;
	coord_t            start_x;
	coord_t            start_y;
	coord_t            ctrl_a_x;
	coord_t            ctrl_a_y;
	coord_t            ctrl_b_x;
	coord_t            ctrl_b_y;
	coord_t            end_x;
	coord_t            end_y;
	logic [StepW-1:0]  step_length;
	modport source(output valid, start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
		end_x, end_y, step_length, input ready);
	modport sink(input valid, start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y,
		end_x, end_y, step_length, output ready);
endinterface
`default_nettype wire

// ===== sv/bzs_out_if.sv =====
// bzs_out_if: result channel of the bezier sampler, one curve point per transfer, last_point on a request's final point
// depends on bzs_pkg
`default_nettype none
interface bzs_out_if;
	import bzs_pkg::*;
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;
	logic   last_point;
	modport source(output valid, point_x, point_y, last_point, input ready);
	modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface
`default_nettype wire

// ===== sv/bzs_isqrt.sv =====
// bzs_isqrt: integer square root, two radicand bits per cycle
// depends on bzs_pkg
`default_nettype none
module bzs_isqrt (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [bzs_pkg::SqW-1:0]    radicand,
	output logic [bzs_pkg::RootW-1:0] root,
	output bzs_pkg::unit_status_t     status
);
	import bzs_pkg::*;

	localparam int RemW = RootW + 2;
	localparam int CntW = $clog2(RootW + 1);

	logic [SqW-1:0]   x_q;
	logic [RemW-1:0]  rem_q;
	logic [RootW-1:0] root_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [RemW+1:0]  rem_sh;
	logic [RemW+1:0]  trial;
	logic             ge;

	always_comb begin
		rem_sh = {rem_q, x_q[SqW-1 -: 2]};
		trial  = {2'b00, root_q, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(RootW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[SqW-3:0], 2'b00};
			rem_q  <= ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
			root_q <= {root_q[RootW-2:0], ge};
		end
	end

	assign root   = root_q;
	assign status = '{busy: busy_q, done: done_q};
endmodule
`default_nettype wire

// ===== sv/bzs_div.sv =====
// bzs_div: restoring unsigned divider, one quotient bit per cycle
// depends on bzs_pkg
`default_nettype none
module bzs_div (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [bzs_pkg::DistW-1:0]  dividend,
	input  wire [bzs_pkg::StepW-1:0]  divisor,
	output logic [bzs_pkg::DistW-1:0] quotient,
	output bzs_pkg::unit_status_t     status
);
	import bzs_pkg::*;

	localparam int CntW = $clog2(DistW);

	logic [DistW-1:0] q_q;
	logic [StepW-1:0] rem_q;
	logic [StepW-1:0] d_q;
	logic [CntW-1:0]  cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [StepW:0]   r_sh;
	logic             ge;

	always_comb begin
		r_sh = {rem_q, q_q[DistW-1]};
		ge   = r_sh >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DistW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[DistW-2:0], ge};
			rem_q <= ge ? StepW'(r_sh - {1'b0, d_q}) : StepW'(r_sh);
		end
	end

	assign quotient = q_q;
	assign status   = '{busy: busy_q, done: done_q};
endmodule
`default_nettype wire

// ===== sv/cubic_bezier_sampler.sv =====
// cubic_bezier_sampler: top level, sequencer, shared multiplier and point datapath
// depends on bzs_pkg, bzs_in_if, bzs_out_if, bzs_isqrt, bzs_div
//
//  channel  dir  payload                                   handshake
//  req      in   four control points (Q16.16), step_length valid/ready
//  rsp      out  point_x, point_y (Q16.16), last_point     valid/ready
//
// one request at a time; req.ready is high only while idle
// polygon length: three segments, each two multiplies on the shared multiplier and a square root
// count: one division of the length by step_length (skipped for zero step length)
// per point: a division for t (interior points only), then two axes of
// six lerps on the shared multiplier and three drops
// arst_n clears the sequencer and the shared unit controls only; a stalled rsp holds the point until taken
`default_nettype none
module cubic_bezier_sampler (
	input  wire          clk,
	input  wire          arst_n,
	bzs_in_if.sink       req,
	bzs_out_if.source    rsp
);
	import bzs_pkg::*;

	state_t state_q, state_d;

	// control points, rotated once per segment so the diff taps stay fixed
	coord_t px_q [4];
	coord_t py_q [4];
	logic [StepW-1:0] step_q;

	// de casteljau working queue
	coord_t w_q [4];
	coord_t res_x_q, res_y_q;

	logic [1:0]       seg_q;
	logic [DistW-1:0] dist_q;
	logic [SqW-1:0]   sq_q;
	logic signed [2*MulW-1:0] prod_q;
	logic [IdxW-1:0]  n_q;
	logic [IdxW-1:0]  idx_q;
	logic [TW-1:0]    t_q;
	logic [OpW-1:0]   op_q;
	logic             axis_q;

	// shared unit hookup
	logic             sq_start, dv_start;
	logic [RootW-1:0] sq_root;
	logic [DistW-1:0] dv_quot;
	logic [DistW-1:0] dv_num;
	logic [StepW-1:0] dv_den;
	unit_status_t     sq_st, dv_st;

	logic signed [CoordW:0] dx, dy, dw;
	logic [CoordW:0]  ax, ay;
	logic signed [MulW-1:0] ma, mb;
	logic [DistW-1:0] dist_sum;
	logic [IdxW-1:0]  last_idx;
	logic             interior;
	logic signed [2*MulW-1:0] lerp_sh;
	coord_t           lerp_new;

	bzs_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(SqW'(sq_q + prod_q[SqW-1:0])),
		.root    (sq_root),
		.status  (sq_st)
	);

	bzs_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dv_start),
		.dividend(dv_num),
		.divisor (dv_den),
		.quotient(dv_quot),
		.status  (dv_st)
	);

	// segment differences and magnitudes
	always_comb begin
		dx = {px_q[1][CoordW-1], px_q[1]} - {px_q[0][CoordW-1], px_q[0]};
		dy = {py_q[1][CoordW-1], py_q[1]} - {py_q[0][CoordW-1], py_q[0]};
		ax = dx[CoordW] ? (CoordW+1)'(-dx) : dx;
		ay = dy[CoordW] ? (CoordW+1)'(-dy) : dy;
		dw = {w_q[1][CoordW-1], w_q[1]} - {w_q[0][CoordW-1], w_q[0]};
		dist_sum = dist_q + DistW'(sq_root);
		last_idx = n_q + 1'b1;
		interior = (idx_q != '0) && (idx_q != last_idx);
		// floor((b-a)*t / 2^16)
		lerp_sh  = prod_q >>> FracW;
		lerp_new = w_q[0] + lerp_sh[CoordW-1:0];
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_SQX: begin
				ma = {1'b0, ax};
				mb = {1'b0, ax};
			end
			S_SQY: begin
				ma = {1'b0, ay};
				mb = {1'b0, ay};
			end
			default: begin
				ma = {dw[CoordW], dw};
				mb = MulW'(t_q);
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (req.valid) state_d = S_SQX;
			S_SQX:   state_d = S_SQY;
			S_SQY:   state_d = S_SQSUM;
			S_SQSUM: state_d = S_SQRT;
			S_SQRT: begin
				if (sq_st.done) begin
					if (seg_q == 2'd2)
						state_d = (step_q == '0) ? S_PT : S_DIVN;
					else
						state_d = S_SQX;
				end
			end
			S_DIVN:  if (dv_st.done) state_d = S_PT;
			S_PT:    state_d = interior ? S_DIVT : S_LOAD;
			S_DIVT:  if (dv_st.done) state_d = S_LOAD;
			S_LOAD:  state_d = S_OP;
			S_OP:    state_d = (OpSeq[op_q] == OP_LERP) ? S_ADD : S_OP;
			S_ADD: begin
				if (op_q == OpW'(OpCnt - 1))
					state_d = axis_q ? S_OUT : S_LOAD;
				else
					state_d = S_OP;
			end
			S_OUT: begin
				if (rsp.ready)
					state_d = (idx_q == last_idx) ? S_IDLE : S_PT;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and unit kicks
	always_comb begin
		req.ready = (state_q == S_IDLE);
		rsp.valid = (state_q == S_OUT);
		sq_start  = (state_q == S_SQSUM);
		dv_start  = 1'b0;
		dv_num    = {{(DistW-IdxW-FracW){1'b0}}, idx_q, {FracW{1'b0}}};
		dv_den    = StepW'(last_idx);
		case (state_q)
			S_SQRT: begin
				dv_start = sq_st.done && (seg_q == 2'd2) && (step_q != '0);
				dv_num   = dist_sum;
				dv_den   = step_q;
			end
			S_PT: dv_start = interior;
			default: ;
		endcase
	end

	assign rsp.point_x    = res_x_q;
	assign rsp.point_y    = res_y_q;
	assign rsp.last_point = (idx_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				px_q   <= '{req.start_x, req.ctrl_a_x, req.ctrl_b_x, req.end_x};
				py_q   <= '{req.start_y, req.ctrl_a_y, req.ctrl_b_y, req.end_y};
				step_q <= req.step_length;
				seg_q  <= '0;
				dist_q <= '0;
			end
			S_SQX: prod_q <= ma * mb;
			S_SQY: begin
				sq_q   <= prod_q[SqW-1:0];
				prod_q <= ma * mb;
			end
			S_SQSUM: begin
				px_q <= '{px_q[1], px_q[2], px_q[3], px_q[0]};
				py_q <= '{py_q[1], py_q[2], py_q[3], py_q[0]};
			end
			S_SQRT: begin
				if (sq_st.done) begin
					dist_q <= dist_sum;
					seg_q  <= seg_q + 1'b1;
					idx_q  <= '0;
					n_q    <= IdxW'(MaxInterior);
					if (seg_q == 2'd2) begin
						// fourth rotation puts the points back in order
						px_q <= '{px_q[1], px_q[2], px_q[3], px_q[0]};
						py_q <= '{py_q[1], py_q[2], py_q[3], py_q[0]};
					end
				end
			end
			S_DIVN: begin
				if (dv_st.done)
					n_q <= (dv_quot > DistW'(MaxInterior)) ? IdxW'(MaxInterior)
						: dv_quot[IdxW-1:0];
			end
			S_PT: begin
				axis_q <= 1'b0;
				t_q    <= (idx_q == '0) ? '0 : {1'b1, {FracW{1'b0}}};
			end
			S_DIVT: if (dv_st.done) t_q <= dv_quot[TW-1:0];
			S_LOAD: begin
				w_q  <= axis_q ? py_q : px_q;
				op_q <= '0;
			end
			S_OP: begin
				if (OpSeq[op_q] == OP_LERP) begin
					prod_q <= ma * mb;
				end else begin
					w_q  <= '{w_q[1], w_q[2], w_q[3], w_q[3]};
					op_q <= op_q + 1'b1;
				end
			end
			S_ADD: begin
				w_q <= '{w_q[1], w_q[2], w_q[3], lerp_new};
				if (op_q == OpW'(OpCnt - 1)) begin
					axis_q <= 1'b1;
					if (axis_q)
						res_y_q <= lerp_new;
					else
						res_x_q <= lerp_new;
				end else begin
					op_q <= op_q + 1'b1;
				end
			end
			S_OUT: if (rsp.ready) idx_q <= idx_q + 1'b1;
			default: ;
		endcase
	end

	// never take a request while a point is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("request taken while point pending");

	// the last point returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && rsp.last_point) |=> req.ready)
		else $error("not idle after last point");

	// interior count never passes its cap
	a_ncap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (n_q <= IdxW'(MaxInterior)))
		else $error("interior count over cap");

	// shared units are never kicked while busy
	a_kick: assert property (@(posedge clk) disable iff (!arst_n)
		!(dv_start && dv_st.busy) && !(sq_start && sq_st.busy))
		else $error("unit restarted while busy");
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for cubic_bezier_sampler, random and directed requests
// depends on bzs_pkg, bzs_in_if, bzs_out_if and the sampler rtl
`default_nettype none
module tb_top;
	import bzs_pkg::*;

	// one request: four control points and the step length
	typedef struct {
		coord_t          px [4];
		coord_t          py [4];
		logic [StepW-1:0] step;
	} curve_req_t;

	// one expected curve point
	typedef struct {
		coord_t x;
		coord_t y;
		logic   last;
	} curve_pt_t;

	logic clk;
	logic arst_n;

	bzs_in_if  req();
	bzs_out_if rsp();

	cubic_bezier_sampler u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	curve_req_t pending_reqs [$];
	curve_pt_t  expected_pts [$];
	int         err_count;
	bit         stim_done;
	bit         hold_req;
	int         no_idle_lo;
	int         no_idle_hi;
	longint     cyc;

	// clock and single reset at start
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) cyc <= cyc + 1;

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cyc, what);
		err_count++;
	endtask

	task automatic add_req(input curve_req_t r);
		pending_reqs = {pending_reqs, r};
	endtask

	// exact floor of the euclidean length of a segment, in q16.16
	function automatic logic [35:0] seg_length(input logic signed [32:0] dx,
			input logic signed [32:0] dy);
		logic [32:0]  ax;
		logic [32:0]  ay;
		logic [67:0]  sq;
		logic [35:0]  root;
		logic [35:0]  cand;
		ax = dx < 0 ? 33'(-dx) : 33'(dx);
		ay = dy < 0 ? 33'(-dy) : 33'(dy);
		sq = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay);
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			cand = root | (36'd1 << b);
			if (72'(cand) * 72'(cand) <= 72'(sq))
				root = cand;
		end
		return root;
	endfunction

	// a + floor((b - a) * t / 2^16), t in q1.16 with one as 65536
	function automatic longint lerp_q16(input longint a, input longint b, input longint t);
		return a + ((b - a) * t >>> FracW);
	endfunction

	function automatic coord_t bezier_axis(input coord_t p [4], input longint t);
		longint a, b, c, d, e;
		a = lerp_q16(p[0], p[1], t);
		b = lerp_q16(p[1], p[2], t);
		c = lerp_q16(p[2], p[3], t);
		d = lerp_q16(a, b, t);
		e = lerp_q16(b, c, t);
		return coord_t'(lerp_q16(d, e, t));
	endfunction

	// sample count from polygon length, then every curve point queued in order
	task automatic predict_curve(input curve_req_t r);
		longint unsigned poly_len;
		longint unsigned interior;
		longint          t;
		int              total;
		curve_pt_t       pt;
		poly_len = 0;
		for (int k = 0; k < 3; k++)
			poly_len += seg_length(33'(r.px[k+1]) - 33'(r.px[k]),
				33'(r.py[k+1]) - 33'(r.py[k]));
		if (r.step == 0)
			interior = MaxInterior;
		else
			interior = poly_len / r.step;
		if (interior > MaxInterior)
			interior = MaxInterior;
		total = int'(interior) + 2;
		for (int i = 0; i < total; i++) begin
			if (i == 0)
				t = 0;
			else if (i == total - 1)
				t = 65536;
			else
				t = (longint'(i) * 65536) / longint'(interior + 1);
			pt.x = bezier_axis(r.px, t);
			pt.y = bezier_axis(r.py, t);
			pt.last = (i == total - 1);
			expected_pts = {expected_pts, pt};
		end
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(5))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
			2: return 32'sh7FFF_FFFF - coord_t'($urandom_range(0, 65535));
			3: return 32'sh8000_0000 + coord_t'($urandom_range(0, 65535));
			default: return coord_t'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
		endcase
	endfunction

	function automatic curve_req_t make_req(input coord_t c0, c1, c2, c3,
			input coord_t d0, d1, d2, d3, input logic [StepW-1:0] s);
		curve_req_t r;
		r.px = '{c0, c1, c2, c3};
		r.py = '{d0, d1, d2, d3};
		r.step = s;
		return r;
	endfunction

	// stimulus: directed corners first, then random curves of mixed size
	initial begin
		curve_req_t r;
		coord_t mx, mn;
		mx = 32'sh7FFF_FFFF;
		mn = 32'sh8000_0000;
		err_count = 0;
		stim_done = 0;
		hold_req = 0;
		cyc = 0;
		// long stretch with no idling on either side
		no_idle_lo = 20_000;
		no_idle_hi = 80_000;
		// coincident control points: two points only
		add_req(make_req(0, 0, 0, 0, 0, 0, 0, 0, 31'd1));
		add_req(make_req(mx, mx, mx, mx, mn, mn, mn, mn, 31'h7FFF_FFFF));
		// zero step length: count saturates
		add_req(make_req(0, 32'sh10000, 32'sh20000, 32'sh30000,
			0, 32'sh10000, 0, 32'sh10000, 31'd0));
		// full-range extremes, saturated and unsaturated counts
		add_req(make_req(mn, mx, mn, mx, mx, mn, mx, mn, 31'd1));
		add_req(make_req(mn, mx, mx, mn, mn, mn, mx, mx, 31'h7FFF_FFFF));
		add_req(make_req(mx, mn, mx, mn, mn, mx, mn, mx, 31'h4000_0000));
		// exact count boundaries: length 3.0 per segment
		add_req(make_req(0, 32'sh30000, 32'sh60000, 32'sh90000,
			0, 0, 0, 0, 31'h30000));
		add_req(make_req(0, 32'sh30000, 32'sh60000, 32'sh90000,
			0, 0, 0, 0, 31'h30001));
		add_req(make_req(0, 32'sh30000, 32'sh60000, 32'sh90000,
			0, 0, 0, 0, 31'h2FFFF));
		// 3-4-5 segments, negative direction
		add_req(make_req(0, -32'sh30000, -32'sh60000, -32'sh90000,
			0, -32'sh40000, -32'sh80000, -32'shC0000, 31'h10000));
		// count right at and past the cap
		add_req(make_req(0, 32'sh3E0000, 32'sh3E0000, 32'sh3E0000,
			0, 0, 0, 0, 31'h10000));
		add_req(make_req(0, 32'sh3F0000, 32'sh3F0000, 32'sh3F0000,
			0, 0, 0, 0, 31'h10000));
		add_req(make_req(-1, 1, -1, 1, 1, -1, 1, -1, 31'd1));
		for (int n = 0; n < 300; n++) begin
			for (int k = 0; k < 4; k++) begin
				r.px[k] = rand_coord();
				r.py[k] = rand_coord();
			end
			case ($urandom_range(5))
				0: r.step = 31'($urandom);
				1: r.step = 31'd0;
				2: r.step = 31'($urandom_range(1, 255));
				default: r.step = 31'h4000_0000 | 31'($urandom);
			endcase
			add_req(r);
		end
		wait (arst_n);
		// pause once until the block has drained everything
		wait (pending_reqs.size() < 150);
		hold_req = 1;
		wait (expected_pts.size() == 0 && !req.valid);
		repeat (20) @(posedge clk);
		hold_req = 0;
		wait (pending_reqs.size() == 0 && !req.valid);
		stim_done = 1;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid       <= 1'b0;
			req.start_x     <= '0;
			req.start_y     <= '0;
			req.ctrl_a_x    <= '0;
			req.ctrl_a_y    <= '0;
			req.ctrl_b_x    <= '0;
			req.ctrl_b_y    <= '0;
			req.end_x       <= '0;
			req.end_y       <= '0;
			req.step_length <= '0;
		end else if (!req.valid || req.ready) begin
			// previous request taken or none shown, so present the next one or idle
			if (req.valid)
				predict_curve(make_req(req.start_x, req.ctrl_a_x, req.ctrl_b_x, req.end_x,
					req.start_y, req.ctrl_a_y, req.ctrl_b_y, req.end_y, req.step_length));
			if (pending_reqs.size() != 0 && !hold_req
					&& ((cyc >= no_idle_lo && cyc < no_idle_hi) || $urandom_range(99) >= 28)) begin
				curve_req_t r;
				r = pending_reqs.pop_front();
				req.valid       <= 1'b1;
				req.start_x     <= r.px[0];
				req.ctrl_a_x    <= r.px[1];
				req.ctrl_b_x    <= r.px[2];
				req.end_x       <= r.px[3];
				req.start_y     <= r.py[0];
				req.ctrl_a_y    <= r.py[1];
				req.ctrl_b_y    <= r.py[2];
				req.end_y       <= r.py[3];
				req.step_length <= r.step;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				curve_pt_t e;
				if (expected_pts.size() == 0) begin
					report_mismatch($sformatf("unexpected point %h %h", rsp.point_x, rsp.point_y));
				end else begin
					e = expected_pts.pop_front();
					if (rsp.point_x !== e.x)
						report_mismatch($sformatf("point_x %h want %h", rsp.point_x, e.x));
					if (rsp.point_y !== e.y)
						report_mismatch($sformatf("point_y %h want %h", rsp.point_y, e.y));
					if (rsp.last_point !== e.last)
						report_mismatch($sformatf("last_point %b want %b", rsp.last_point, e.last));
				end
			end
			rsp.ready <= (cyc >= no_idle_lo && cyc < no_idle_hi) || $urandom_range(99) >= 28;
		end
	end

	// end of run once all requests are in and every point has come back
	initial begin
		wait (stim_done);
		wait (expected_pts.size() == 0);
		repeat (200) @(posedge clk);
		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog: stops a hung run with TB_ERROR; ~320 requests of up to 64 points each
	initial begin
		#(12 * 12_000_000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
`default_nettype wire
